>>> rtl/bfmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmd_pkg
// Shared types and constants for the 2x2 box-filter mip downsample unit.
// ----------------------------------------------------------------------------
package bfmd_pkg;

    // Default largest source extent; the top level takes it as a parameter
    localparam int MAX_DIMENSION_DEF = 16384;

    // Fixed field widths
    localparam int DIM_W   = 15;
    localparam int CH_W    = 3;
    localparam int PIX_W   = 8;
    localparam int PAIR_W  = PIX_W + 1;
    localparam int SUM_W   = PIX_W + 2;
    localparam int NUM_CH  = 4;
    localparam int ROW_W   = NUM_CH * PAIR_W;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int PROD_W  = 2 * DIM_W;
    localparam int TEX_W   = PROD_W + CH_W;

    // Largest texture in bytes (256 MiB)
    localparam logic [TEX_W-1:0] TEXTURE_BYTE_CAP = TEX_W'(64'd268435456);

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    // Register reset values and channel count codes
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1);
    localparam logic [CH_W-1:0]  CH_RGB       = CH_W'(3);
    localparam logic [CH_W-1:0]  CH_RGBA      = CH_W'(4);

    // Input item
    typedef struct packed {
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
        logic [PIX_W-1:0] in_alpha;
    } pixel_in_t;

    // Result item
    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_alpha;
        logic             image_end;
    } pixel_out_t;

    // Row store access controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctrl_t;

endpackage

>>> rtl/box_filter_mip_downsample_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_mip_downsample_unit
// One level of 2x2 box-filter mip reduction over a raster pixel stream.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order at one item per clock when s_ready is
// high (it drops while the output stalls); a mip pixel leaves on the item
// that carries its bottom-right source pixel, after that item passes through
// the row store read stage and the output register. The pair sums of each even
// source row sit in a MAX_DIMENSION/2 x 36 row store that is written and read
// by the input stage; an entry is always written a full row before it is read,
// so no forwarding is needed. After reset and after every write to a known
// register the size check runs, during which s_ready is low. A configuration
// that fails the check (extent outside 1..MAX_DIMENSION, channel count not 3 or
// 4, or more than 256 MiB of texture) consumes items and produces no results.
// ----------------------------------------------------------------------------
module box_filter_mip_downsample_unit
    import bfmd_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Source pixels
    input  logic               s_valid,
    output logic               s_ready,
    input  pixel_in_t          s_data,
    // Mip pixels
    output logic               m_valid,
    input  logic               m_ready,
    output pixel_out_t         m_data,
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CNT_W       = $clog2(MAX_DIMENSION);
    localparam int STORE_DEPTH = MAX_DIMENSION / 2;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIMENSION);

    // Configuration registers
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [CH_W-1:0]  chan_reg;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    // Size check pipeline
    logic [1:0]        chk_busy_reg;
    logic [PROD_W-1:0] wh_reg;
    logic              range_ok_reg;
    logic              cfg_ok_reg;
    logic              halve_x_reg, halve_y_reg;
    logic [DIM_W-1:0]  mip_w_reg, mip_h_reg;

    // Position and held pixel
    logic [CNT_W-1:0] col_reg, row_reg;
    logic [CNT_W-1:0] col_next, row_next;
    logic [NUM_CH-1:0][PIX_W-1:0] held_reg;

    // Input stage
    logic                          accept, take;
    logic [NUM_CH-1:0][PIX_W-1:0]  px;
    logic [NUM_CH-1:0][PAIR_W-1:0] hs;
    logic                          have_pair, even_row_wr, emit, last_pix;
    logic [DIM_W-1:0]              col_inc, row_inc, x_inc, y_inc;
    logic [CNT_W-1:0]              y_pos;
    logic [ADDR_W-1:0]             store_addr;
    store_ctrl_t                   store_ctrl;
    logic [ROW_W-1:0]              store_rdata;

    // Read-data stage and output register
    logic                          s1_valid_reg, s1_free;
    logic                          s1_mem_reg, s1_end_reg;
    logic [NUM_CH-1:0][PAIR_W-1:0] s1_hs_reg;
    logic [NUM_CH-1:0][PAIR_W-1:0] top_hs;
    logic [NUM_CH-1:0][SUM_W-1:0]  sum;
    logic                          m_valid_reg;
    pixel_out_t                    m_data_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_SOURCE_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_SOURCE_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_CHANNEL_COUNT: prdata = PDATA_W'(chan_reg);
            default:           prdata = '0;
        endcase
    end

    // Write registers; any known register restarts the check
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            chan_reg     <= CH_RGBA;
            chk_busy_reg <= 2'd2;
        end else begin
            if (chk_busy_reg != 2'd0) begin
                chk_busy_reg <= chk_busy_reg - 2'd1;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_SOURCE_WIDTH: begin
                        width_reg    <= pwdata[DIM_W-1:0];
                        chk_busy_reg <= 2'd2;
                    end
                    REG_SOURCE_HEIGHT: begin
                        height_reg   <= pwdata[DIM_W-1:0];
                        chk_busy_reg <= 2'd2;
                    end
                    REG_CHANNEL_COUNT: begin
                        chan_reg     <= pwdata[CH_W-1:0];
                        chk_busy_reg <= 2'd2;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------- size check ----------------
    // First stage: area, range flags, halving flags and mip extents
    always_ff @(posedge aclk) begin
        wh_reg       <= PROD_W'(width_reg) * PROD_W'(height_reg);
        range_ok_reg <= (width_reg >= DIM_W'(1)) && (width_reg <= MAX_DIM_V) &&
                        (height_reg >= DIM_W'(1)) && (height_reg <= MAX_DIM_V) &&
                        ((chan_reg == CH_RGB) || (chan_reg == CH_RGBA));
        halve_x_reg  <= width_reg > DIM_W'(1);
        halve_y_reg  <= height_reg > DIM_W'(1);
        mip_w_reg    <= (width_reg > DIM_W'(1)) ? (width_reg >> 1) : DIM_W'(1);
        mip_h_reg    <= (height_reg > DIM_W'(1)) ? (height_reg >> 1) : DIM_W'(1);
    end

    // Second stage: byte count against the texture limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_ok_reg <= 1'b0;
        end else begin
            cfg_ok_reg <= range_ok_reg &&
                          ((TEX_W'(wh_reg) * TEX_W'(chan_reg)) <= TEXTURE_BYTE_CAP);
        end
    end

    // ---------------- input stage ----------------
    assign s1_free = !s1_valid_reg || !m_valid_reg || m_ready;
    assign s_ready = (chk_busy_reg == 2'd0) && s1_free;
    assign accept  = s_valid && s_ready;
    assign take    = accept && cfg_ok_reg;

    // Zero alpha for RGB, form horizontal pair sums (or double when not halving horizontally)
    always_comb begin
        px[0] = s_data.in_red;
        px[1] = s_data.in_green;
        px[2] = s_data.in_blue;
        px[3] = (chan_reg == CH_RGB) ? '0 : s_data.in_alpha;
        for (int i = 0; i < NUM_CH; i++) begin
            if (halve_x_reg) begin
                hs[i] = PAIR_W'(held_reg[i]) + PAIR_W'(px[i]);
            end else begin
                hs[i] = {px[i], 1'b0};
            end
        end
    end

    assign have_pair   = !halve_x_reg || col_reg[0];
    assign even_row_wr = halve_y_reg && !row_reg[0];
    assign emit        = have_pair && !even_row_wr;
    assign store_addr  = halve_x_reg ? ADDR_W'(col_reg >> 1) : '0;

    assign store_ctrl.wr_en = take && have_pair && even_row_wr;
    assign store_ctrl.rd_en = take && have_pair && halve_y_reg && row_reg[0];

    // Last mip pixel of the image
    assign y_pos    = halve_y_reg ? (row_reg >> 1) : row_reg;
    assign x_inc    = DIM_W'(store_addr) + DIM_W'(1);
    assign y_inc    = DIM_W'(y_pos) + DIM_W'(1);
    assign last_pix = (x_inc == mip_w_reg) && (y_inc == mip_h_reg);

    // Advance the raster position
    assign col_inc = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc = DIM_W'(row_reg) + DIM_W'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= width_reg) begin
            col_next = '0;
            row_next = (row_inc >= height_reg) ? '0 : CNT_W'(row_inc);
        end else begin
            col_next = CNT_W'(col_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end else if (cfg_wr && (cfg_idx == REG_SOURCE_WIDTH ||
                                cfg_idx == REG_SOURCE_HEIGHT ||
                                cfg_idx == REG_CHANNEL_COUNT)) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (take) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (halve_x_reg && !col_reg[0]) begin
                held_reg <= px;
            end
        end
    end

    bfmd_row_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_row_store (
        .aclk  (aclk),
        .ctrl  (store_ctrl),
        .addr  (store_addr),
        .wdata (hs),
        .rdata (store_rdata)
    );

    // ---------------- read-data stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= take && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_free && take) begin
            s1_hs_reg  <= hs;
            s1_mem_reg <= halve_y_reg;
            s1_end_reg <= last_pix;
        end
    end

    // Add the stored even-row sums, or double when not halving vertically
    assign top_hs = store_rdata;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (s1_mem_reg) begin
                sum[i] = SUM_W'(top_hs[i]) + SUM_W'(s1_hs_reg[i]);
            end else begin
                sum[i] = {s1_hs_reg[i], 1'b0};
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if ((!m_valid_reg || m_ready) && s1_valid_reg) begin
            m_data_reg.out_red   <= sum[0][SUM_W-1:2];
            m_data_reg.out_green <= sum[1][SUM_W-1:2];
            m_data_reg.out_blue  <= sum[2][SUM_W-1:2];
            m_data_reg.out_alpha <= sum[3][SUM_W-1:2];
            m_data_reg.image_end <= s1_end_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    // Column stays inside a checked width
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_ok_reg && chk_busy_reg == 2'd0) |-> (DIM_W'(col_reg) < width_reg))
        else $error("column position beyond source width");

    // Row stays inside a checked height
    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_ok_reg && chk_busy_reg == 2'd0) |-> (DIM_W'(row_reg) < height_reg))
        else $error("row position beyond source height");

    // Row store is never read and written by the same item
    a_store_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(store_ctrl.wr_en && store_ctrl.rd_en))
        else $error("row store read and write in one cycle");

    // A pending result only appears after an accepted item
    a_s1_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s1_valid_reg) |-> $past(s_valid && s_ready && cfg_ok_reg))
        else $error("result without an accepted item");

    // No item is taken while the size check is running
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cfg_wr && (cfg_idx == REG_SOURCE_WIDTH ||
                         cfg_idx == REG_SOURCE_HEIGHT ||
                         cfg_idx == REG_CHANNEL_COUNT)) |-> !s_ready)
        else $error("item taken during size check");

endmodule

>>> rtl/bfmd_row_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmd_row_store
// Single-port row memory holding the horizontal pair sums of an even row,
// one registered read per cycle.
// ----------------------------------------------------------------------------
module bfmd_row_store
    import bfmd_pkg::*;
#(
    parameter int DEPTH  = MAX_DIMENSION_DEF / 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  store_ctrl_t       ctrl,
    input  logic [ADDR_W-1:0] addr,
    input  logic [ROW_W-1:0]  wdata,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    // Write pair sums of an even row
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[addr] <= wdata;
        end
    end

    // Read and hold until the next read
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
